>>> hw/rtl/sclt_pkg.sv
// Package with the shared types and constants of the serial command line tokenizer.
package sclt_pkg;

  localparam int MAX_ARGS = 10;
  localparam int ARG_IDX_W = 4;
  localparam int QUEUE_DEPTH = 4;
  localparam int QUEUE_PTR_W = 2;
  localparam int QUEUE_CNT_W = 3;

  localparam logic [1:0] KIND_CODE = 2'd0;
  localparam logic [1:0] KIND_ARG  = 2'd1;
  localparam logic [1:0] KIND_END  = 2'd2;

  localparam logic [7:0] CHAR_LF       = 8'h0A;
  localparam logic [7:0] CHAR_QUESTION = 8'h3F;
  localparam logic [7:0] CHAR_SPACE    = 8'h20;
  localparam logic [7:0] CHAR_TAB      = 8'h09;
  localparam logic [7:0] CHAR_CR       = 8'h0D;
  localparam logic [7:0] CHAR_PLUS     = 8'h2B;
  localparam logic [7:0] CHAR_MINUS    = 8'h2D;
  localparam logic [7:0] CHAR_ZERO     = 8'h30;
  localparam logic [7:0] CHAR_NINE     = 8'h39;

  localparam logic [31:0] MAG_LIMIT = 32'h8000_0000;
  localparam logic [31:0] POS_MAX   = 32'h7FFF_FFFF;

  typedef struct packed {
    logic [1:0]           item_kind;
    logic [7:0]           code_char;
    logic [ARG_IDX_W-1:0] arg_slot;
    logic signed [31:0]   arg_value;
    logic                 is_request;
    logic [ARG_IDX_W-1:0] arg_total;
    logic                 too_many_args;
    logic                 last_of_run;
  } result_t;

  typedef struct packed {
    logic [1:0] n;
    result_t    r0;
    result_t    r1;
  } push_t;

  typedef struct packed {
    logic                 line_started;
    logic                 in_arguments;
    logic                 request_seen;
    logic                 arg_has_chars;
    logic                 arg_negative;
    logic                 arg_sign_or_digit_seen;
    logic                 arg_number_stopped;
    logic [31:0]          arg_accum;
    logic [ARG_IDX_W-1:0] arg_index;
    logic                 overflow_seen;
  } state_t;

endpackage

>>> hw/rtl/sclt_parser.sv
// Line parser: running state per byte and the results that each byte produces.
module sclt_parser (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_fire,
  input  logic [7:0]      in_byte,
  output sclt_pkg::push_t push
);
  import sclt_pkg::*;

  state_t      st_r;
  state_t      st_nxt;
  logic        is_nl;
  logic        is_ws;
  logic        is_digit;
  logic        is_sign;
  logic        can_store;
  logic [31:0] arg_bits;
  logic [35:0] acc_mul;
  result_t     arg_res;
  result_t     end_res;
  push_t       push_c;

  assign is_nl    = (in_byte == CHAR_LF);
  assign is_ws    = (in_byte == CHAR_SPACE) || ((in_byte >= CHAR_TAB) && (in_byte <= CHAR_CR));
  assign is_digit = (in_byte >= CHAR_ZERO) && (in_byte <= CHAR_NINE);
  assign is_sign  = (in_byte == CHAR_PLUS) || (in_byte == CHAR_MINUS);
  assign can_store = (st_r.arg_index < ARG_IDX_W'(MAX_ARGS));

  // The magnitude never exceeds two to the power 31, so bit 31 alone marks the limit.
  assign arg_bits = st_r.arg_negative ? (32'd0 - st_r.arg_accum) :
                    (st_r.arg_accum[31] ? POS_MAX : st_r.arg_accum);

  assign acc_mul = {1'b0, st_r.arg_accum, 3'b000} + {3'b000, st_r.arg_accum, 1'b0}
                 + {32'd0, in_byte[3:0] - CHAR_ZERO[3:0]};

  always_comb begin
    arg_res           = '0;
    arg_res.item_kind = KIND_ARG;
    arg_res.arg_slot  = st_r.arg_index;
    arg_res.arg_value = arg_bits;
  end

  always_comb begin
    st_nxt = st_r;
    push_c = '0;
    end_res = '0;
    end_res.item_kind = KIND_END;
    end_res.is_request = st_r.request_seen;
    end_res.arg_total = st_r.arg_index;
    end_res.too_many_args = st_r.overflow_seen;
    end_res.last_of_run = 1'b1;
    if (in_fire) begin
      priority if (is_nl) begin
        if (st_r.line_started) begin
          if (st_r.arg_has_chars && can_store) begin
            end_res.arg_total = st_r.arg_index + 1'b1;
            push_c.r0 = arg_res;
            push_c.r1 = end_res;
            push_c.n  = 2'd2;
          end else begin
            if (st_r.arg_has_chars) begin
              end_res.too_many_args = 1'b1;
            end
            push_c.r0 = end_res;
            push_c.n  = 2'd1;
          end
          st_nxt = '0;
        end
      end else if (!st_r.line_started && (in_byte == CHAR_QUESTION)) begin
        st_nxt.line_started = 1'b1;
        st_nxt.request_seen = 1'b1;
      end else begin
        st_nxt.line_started = 1'b1;
        if (is_ws) begin
          if (!st_r.in_arguments) begin
            st_nxt.in_arguments = 1'b1;
          end else begin
            if (can_store) begin
              push_c.r0 = arg_res;
              push_c.r0.last_of_run = 1'b1;
              push_c.n  = 2'd1;
              st_nxt.arg_index = st_r.arg_index + 1'b1;
            end else begin
              st_nxt.overflow_seen = 1'b1;
            end
            st_nxt.arg_has_chars = 1'b0;
            st_nxt.arg_negative = 1'b0;
            st_nxt.arg_sign_or_digit_seen = 1'b0;
            st_nxt.arg_number_stopped = 1'b0;
            st_nxt.arg_accum = '0;
          end
        end else if (st_r.in_arguments) begin
          st_nxt.arg_has_chars = 1'b1;
          if (!st_r.arg_number_stopped) begin
            priority if (is_digit) begin
              st_nxt.arg_accum = (acc_mul > {4'd0, MAG_LIMIT}) ? MAG_LIMIT : acc_mul[31:0];
              st_nxt.arg_sign_or_digit_seen = 1'b1;
            end else if (is_sign && !st_r.arg_sign_or_digit_seen) begin
              st_nxt.arg_sign_or_digit_seen = 1'b1;
              st_nxt.arg_negative = (in_byte == CHAR_MINUS);
            end else begin
              st_nxt.arg_number_stopped = 1'b1;
            end
          end
        end else begin
          push_c.r0.item_kind = KIND_CODE;
          push_c.r0.code_char = in_byte;
          push_c.r0.last_of_run = 1'b1;
          push_c.n = 2'd1;
        end
      end
    end
  end

  assign push = push_c;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= '0;
    end else begin
      st_r <= st_nxt;
    end
  end

  a_idx_bound: assert property (@(posedge clk) disable iff (!rst_n)
    st_r.arg_index <= ARG_IDX_W'(MAX_ARGS))
    else $error("argument index beyond limit");

  a_pair_order: assert property (@(posedge clk) disable iff (!rst_n)
    (push_c.n == 2'd2) |-> (push_c.r0.item_kind == KIND_ARG) &&
                           (push_c.r1.item_kind == KIND_END) && !push_c.r0.last_of_run)
    else $error("two results must be an argument followed by the line end");

  a_line_clear: assert property (@(posedge clk) disable iff (!rst_n)
    (in_fire && is_nl && st_r.line_started) |=> (st_r == '0))
    else $error("line state not cleared after newline");

endmodule

>>> hw/rtl/sclt_out_queue.sv
// Output queue that takes up to two results per cycle and delivers one per cycle while out_ready is high.
module sclt_out_queue (
  input  logic              clk,
  input  logic              rst_n,
  input  sclt_pkg::push_t   push,
  output logic              room,
  output logic              out_valid,
  input  logic              out_ready,
  output sclt_pkg::result_t out_res
);
  import sclt_pkg::*;

  result_t                q_r [QUEUE_DEPTH];
  logic [QUEUE_PTR_W-1:0] wr_ptr_r;
  logic [QUEUE_PTR_W-1:0] wr_ptr_nxt;
  logic [QUEUE_PTR_W-1:0] rd_ptr_r;
  logic [QUEUE_PTR_W-1:0] rd_ptr_nxt;
  logic [QUEUE_CNT_W-1:0] cnt_r;
  logic [QUEUE_CNT_W-1:0] cnt_nxt;
  logic                   pop;
  logic [QUEUE_PTR_W-1:0] wr_ptr_p1;

  assign out_valid = (cnt_r != '0);
  assign pop       = out_valid && out_ready;
  assign room      = (cnt_r <= QUEUE_CNT_W'(QUEUE_DEPTH - 2));
  assign out_res   = q_r[rd_ptr_r];
  assign wr_ptr_p1 = wr_ptr_r + 1'b1;

  assign wr_ptr_nxt = wr_ptr_r + QUEUE_PTR_W'(push.n);
  assign rd_ptr_nxt = rd_ptr_r + QUEUE_PTR_W'(pop);
  assign cnt_nxt    = cnt_r + QUEUE_CNT_W'(push.n) - QUEUE_CNT_W'(pop);

  always_ff @(posedge clk) begin
    if (push.n != 2'd0) begin
      q_r[wr_ptr_r] <= push.r0;
    end
    if (push.n == 2'd2) begin
      q_r[wr_ptr_p1] <= push.r1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= QUEUE_CNT_W'(QUEUE_DEPTH))
    else $error("output queue overfilled");

  a_push_room: assert property (@(posedge clk) disable iff (!rst_n)
    (push.n != 2'd0) |-> room)
    else $error("results pushed without room");

  a_ptr_gap: assert property (@(posedge clk) disable iff (!rst_n)
    (cnt_r != QUEUE_CNT_W'(QUEUE_DEPTH)) |->
      (QUEUE_PTR_W'(wr_ptr_r - rd_ptr_r) == cnt_r[QUEUE_PTR_W-1:0]))
    else $error("queue pointers disagree with count");

endmodule

>>> hw/rtl/serial_command_line_tokenizer_top.sv
// Top level of the serial command line tokenizer.
//
//   channel  direction  ports
//   in       input      in_valid, in_ready, in_rx_byte
//   out      output     out_valid, out_ready, out_item_kind ... out_last_of_run
//
// A byte is taken in the cycle it is accepted; its results are in the output queue
// on the next cycle. One byte can be accepted every cycle while in_ready is high;
// a newline may produce two results, which leave the four-entry output queue one
// per cycle while out_ready is high.
// in_ready is high while the queue holds at most two results.
// Reset is synchronous and active low; it clears the line state and empties the queue.
module serial_command_line_tokenizer_top (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [7:0]         in_rx_byte,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [1:0]         out_item_kind,
  output logic [7:0]         out_code_char,
  output logic [3:0]         out_arg_slot_out,
  output logic signed [31:0] out_arg_value_out,
  output logic               out_is_request,
  output logic [3:0]         out_arg_total,
  output logic               out_too_many_args,
  output logic               out_last_of_run
);
  import sclt_pkg::*;

  push_t   push;
  result_t res;
  logic    room;
  logic    in_fire;

  assign in_ready = room;
  assign in_fire  = in_valid && room;

  sclt_parser u_parser (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_fire (in_fire),
    .in_byte (in_rx_byte),
    .push    (push)
  );

  sclt_out_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .room      (room),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_res   (res)
  );

  assign out_item_kind     = res.item_kind;
  assign out_code_char     = res.code_char;
  assign out_arg_slot_out  = res.arg_slot;
  assign out_arg_value_out = res.arg_value;
  assign out_is_request    = res.is_request;
  assign out_arg_total     = res.arg_total;
  assign out_too_many_args = res.too_many_args;
  assign out_last_of_run   = res.last_of_run;

endmodule

>>> tb/sv/tb_serial_command_line_tokenizer_top.sv
// Self-checking testbench of the serial command line tokenizer top level.
module tb_serial_command_line_tokenizer_top;
  timeunit 1ns;
  timeprecision 1ps;

  import sclt_pkg::*;

  localparam logic [7:0] CHAR_VT = 8'h0B;
  localparam logic [7:0] CHAR_FF = 8'h0C;
  localparam int HOLD_CYCLES = 250;

  typedef enum logic [1:0] {BY_MODEL, NO_RESULT, ONE_RESULT} check_mode_t;

  typedef struct packed {
    logic [7:0]  rx;
    check_mode_t mode;
    result_t     r;
  } stim_row_t;

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               in_valid = 1'b0;
  logic               in_ready;
  logic [7:0]         in_rx_byte = 8'h00;
  logic               out_valid;
  logic               out_ready = 1'b0;
  logic [1:0]         out_item_kind;
  logic [7:0]         out_code_char;
  logic [3:0]         out_arg_slot_out;
  logic signed [31:0] out_arg_value_out;
  logic               out_is_request;
  logic [3:0]         out_arg_total;
  logic               out_too_many_args;
  logic               out_last_of_run;

  // Tokenizer state of the predictor.
  logic        ln_started = 1'b0;
  logic        in_args = 1'b0;
  logic        req_seen = 1'b0;
  logic        arg_chars = 1'b0;
  logic        arg_neg = 1'b0;
  logic        arg_signed = 1'b0;
  logic        arg_stopped = 1'b0;
  logic [31:0] arg_mag = '0;
  logic [3:0]  arg_count = '0;
  logic        args_dropped = 1'b0;

  result_t   new_tokens[$];
  result_t   expected_tokens[$];
  result_t   oldest;
  stim_row_t directed_rows[$];
  int        mismatches = 0;
  int        bytes_sent = 0;
  int        send_idle_pct = 0;
  int        recv_idle_pct = 0;
  int        hold_trigger = 0;
  int        hold_seen = 0;
  int        hold_left = 0;

  serial_command_line_tokenizer_top dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_rx_byte        (in_rx_byte),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_item_kind     (out_item_kind),
    .out_code_char     (out_code_char),
    .out_arg_slot_out  (out_arg_slot_out),
    .out_arg_value_out (out_arg_value_out),
    .out_is_request    (out_is_request),
    .out_arg_total     (out_arg_total),
    .out_too_many_args (out_too_many_args),
    .out_last_of_run   (out_last_of_run)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  function automatic logic is_blank(input logic [7:0] c);
    return c == CHAR_SPACE || (c >= CHAR_TAB && c <= CHAR_CR);
  endfunction

  function automatic result_t code_res(input logic [7:0] c);
    result_t r;
    r = '0;
    r.item_kind = KIND_CODE;
    r.code_char = c;
    r.last_of_run = 1'b1;
    return r;
  endfunction

  function automatic result_t arg_res(input logic [3:0] slot, input logic [31:0] value);
    result_t r;
    r = '0;
    r.item_kind = KIND_ARG;
    r.arg_slot = slot;
    r.arg_value = value;
    r.last_of_run = 1'b1;
    return r;
  endfunction

  function automatic result_t end_res(input logic req, input logic [3:0] total,
                                      input logic many);
    result_t r;
    r = '0;
    r.item_kind = KIND_END;
    r.is_request = req;
    r.arg_total = total;
    r.too_many_args = many;
    r.last_of_run = 1'b1;
    return r;
  endfunction

  function automatic stim_row_t row(input logic [7:0] rx, input check_mode_t mode,
                                    input result_t r);
    stim_row_t s;
    s.rx = rx;
    s.mode = mode;
    s.r = r;
    return s;
  endfunction

  task automatic clear_argument();
    arg_chars = 1'b0;
    arg_neg = 1'b0;
    arg_signed = 1'b0;
    arg_stopped = 1'b0;
    arg_mag = '0;
  endtask

  task automatic close_argument();
    logic [31:0] value;
    if (arg_count < MAX_ARGS) begin
      if (arg_neg) begin
        value = -arg_mag;
      end else begin
        value = (arg_mag > POS_MAX) ? POS_MAX : arg_mag;
      end
      new_tokens.push_back(arg_res(arg_count, value));
      new_tokens[new_tokens.size()-1].last_of_run = 1'b0;
      arg_count = arg_count + 1'b1;
    end else begin
      args_dropped = 1'b1;
    end
    clear_argument();
  endtask

  task automatic take_arg_char(input logic [7:0] c);
    logic [39:0] wide;
    arg_chars = 1'b1;
    if (!arg_stopped) begin
      if (c >= CHAR_ZERO && c <= CHAR_NINE) begin
        wide = {8'd0, arg_mag} * 40'd10 + {32'd0, c - CHAR_ZERO};
        arg_mag = (wide > {8'd0, MAG_LIMIT}) ? MAG_LIMIT : wide[31:0];
        arg_signed = 1'b1;
      end else if ((c == CHAR_PLUS || c == CHAR_MINUS) && !arg_signed) begin
        arg_signed = 1'b1;
        arg_neg = (c == CHAR_MINUS);
      end else begin
        arg_stopped = 1'b1;
      end
    end
  endtask

  // Advances the tokenizer by one byte and leaves the tokens it yields in new_tokens.
  task automatic tokenize_byte(input logic [7:0] c);
    result_t r;
    new_tokens.delete();
    if (c == CHAR_LF) begin
      if (ln_started) begin
        if (arg_chars) close_argument();
        r = end_res(req_seen, arg_count, args_dropped);
        r.last_of_run = 1'b0;
        new_tokens.push_back(r);
        ln_started = 1'b0;
        in_args = 1'b0;
        req_seen = 1'b0;
        arg_count = '0;
        args_dropped = 1'b0;
        clear_argument();
      end
    end else if (!ln_started && c == CHAR_QUESTION) begin
      ln_started = 1'b1;
      req_seen = 1'b1;
    end else begin
      ln_started = 1'b1;
      if (is_blank(c)) begin
        if (!in_args) in_args = 1'b1;
        else close_argument();
      end else if (in_args) begin
        take_arg_char(c);
      end else begin
        r = code_res(c);
        r.last_of_run = 1'b0;
        new_tokens.push_back(r);
      end
    end
    if (new_tokens.size() > 0) new_tokens[new_tokens.size()-1].last_of_run = 1'b1;
  endtask

  task automatic send_row(input stim_row_t s);
    if ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
    end
    in_valid <= 1'b1;
    in_rx_byte <= s.rx;
    do @(posedge clk); while (!in_ready);
    tokenize_byte(s.rx);
    if (s.mode == BY_MODEL) begin
      foreach (new_tokens[k]) expected_tokens.push_back(new_tokens[k]);
    end else if (s.mode == ONE_RESULT) begin
      expected_tokens.push_back(s.r);
    end
    bytes_sent++;
  endtask

  task automatic send_byte(input logic [7:0] c);
    send_row(row(c, BY_MODEL, '0));
  endtask

  function automatic logic [7:0] blank_pick();
    unique case ($urandom_range(7))
      0: return CHAR_TAB;
      1: return CHAR_VT;
      2: return CHAR_FF;
      3: return CHAR_CR;
      default: return CHAR_SPACE;
    endcase
  endfunction

  function automatic logic [7:0] code_pick();
    logic [7:0] c;
    do c = 8'($urandom_range(255)); while (is_blank(c) || c == CHAR_LF);
    return c;
  endfunction

  // Mostly well-formed lines with random content; the rest is noise that breaks lines.
  task automatic random_line();
    int n_args;
    int n_dig;
    int a;
    int k;
    string bound;
    logic [7:0] c;
    if ($urandom_range(99) < 15) begin
      repeat ($urandom_range(12, 1)) begin
        c = ($urandom_range(3) == 0) ? CHAR_LF : 8'($urandom_range(255));
        send_byte(c);
      end
    end else begin
      if ($urandom_range(3) == 0) send_byte(CHAR_QUESTION);
      repeat ($urandom_range(4)) send_byte(code_pick());
      n_args = ($urandom_range(7) == 0) ? $urandom_range(14, 11) : $urandom_range(5);
      if (n_args > 0 || $urandom_range(1)) send_byte(blank_pick());
      for (a = 0; a < n_args; a++) begin
        if (a > 0) begin
          send_byte(blank_pick());
          if ($urandom_range(9) == 0) send_byte(blank_pick());
        end
        if ($urandom_range(9) < 3) send_byte($urandom_range(1) ? CHAR_MINUS : CHAR_PLUS);
        if ($urandom_range(9) == 0) begin
          bound = $urandom_range(1) ? "2147483647" : "2147483648";
          for (k = 0; k < bound.len(); k++) send_byte(bound[k]);
        end else begin
          n_dig = ($urandom_range(9) == 0) ? $urandom_range(12, 10) : $urandom_range(4);
          repeat (n_dig) begin
            c = CHAR_ZERO + 8'($urandom_range(9));
            send_byte(c);
          end
        end
        if ($urandom_range(9) < 2) begin
          send_byte(code_pick());
          if ($urandom_range(1)) send_byte(CHAR_NINE);
        end
      end
      if ($urandom_range(4) == 0) send_byte(blank_pick());
      send_byte(CHAR_LF);
    end
  endtask

  task automatic check_field(input string name, input logic [31:0] want,
                             input logic [31:0] got);
    if (want !== got) begin
      $display("%0t: %s expected %0h actual %0h", $time, name, want, got);
      mismatches++;
    end
  endtask

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      if (expected_tokens.size() == 0) begin
        $display("%0t: unexpected result, kind %0d", $time, out_item_kind);
        mismatches++;
      end else begin
        oldest = expected_tokens.pop_front();
        check_field("item_kind", 32'(oldest.item_kind), 32'(out_item_kind));
        check_field("code_char", 32'(oldest.code_char), 32'(out_code_char));
        check_field("arg_slot_out", 32'(oldest.arg_slot), 32'(out_arg_slot_out));
        check_field("arg_value_out", oldest.arg_value, out_arg_value_out);
        check_field("is_request", 32'(oldest.is_request), 32'(out_is_request));
        check_field("arg_total", 32'(oldest.arg_total), 32'(out_arg_total));
        check_field("too_many_args", 32'(oldest.too_many_args), 32'(out_too_many_args));
        check_field("last_of_run", 32'(oldest.last_of_run), 32'(out_last_of_run));
      end
    end
  end

  always @(posedge clk) begin
    if (hold_left == 0 && hold_seen != hold_trigger) begin
      hold_seen = hold_trigger;
      hold_left = HOLD_CYCLES;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  initial begin
    #400000;
    $display("FAILED: results differ");
    $finish;
  end

  initial begin
    directed_rows.push_back(row(CHAR_LF, NO_RESULT, '0));
    directed_rows.push_back(row(CHAR_QUESTION, NO_RESULT, '0));
    directed_rows.push_back(row(8'hFF, ONE_RESULT, code_res(8'hFF)));
    directed_rows.push_back(row(8'h00, ONE_RESULT, code_res(8'h00)));
    directed_rows.push_back(row(CHAR_LF, ONE_RESULT, end_res(1'b1, 4'd0, 1'b0)));
    directed_rows.push_back(row(8'h41, ONE_RESULT, code_res(8'h41)));
    directed_rows.push_back(row(CHAR_SPACE, NO_RESULT, '0));
    repeat (10) directed_rows.push_back(row(CHAR_NINE, BY_MODEL, '0));
    directed_rows.push_back(row(CHAR_TAB, ONE_RESULT, arg_res(4'd0, POS_MAX)));
    directed_rows.push_back(row(CHAR_VT, ONE_RESULT, arg_res(4'd1, 32'd0)));
    directed_rows.push_back(row(CHAR_MINUS, BY_MODEL, '0));
    directed_rows.push_back(row(8'h80, BY_MODEL, '0));
    directed_rows.push_back(row(CHAR_CR, ONE_RESULT, arg_res(4'd2, 32'd0)));
    directed_rows.push_back(row(CHAR_LF, ONE_RESULT, end_res(1'b0, 4'd3, 1'b0)));

    send_idle_pct = 34;
    recv_idle_pct = 71;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    foreach (directed_rows[k]) send_row(directed_rows[k]);

    while (bytes_sent < 310) random_line();
    send_idle_pct = 71;
    recv_idle_pct = 34;
    while (bytes_sent < 600) random_line();
    send_idle_pct = 0;
    recv_idle_pct = 0;
    hold_trigger <= hold_trigger + 1;
    while (bytes_sent < 840) random_line();

    in_valid <= 1'b0;
    while (expected_tokens.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (mismatches == 0 && expected_tokens.size() == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule
